>>> rtl/ssma_pkg.sv
// Shared types and constants for the stereo mix accumulator.
package ssma_pkg;

  // Accumulator store geometry (power of two)
  localparam int MIX_DEPTH = 4096;
  localparam int MIX_AW    = $clog2(MIX_DEPTH);

  localparam int POS_W    = 12;
  localparam int SAMPLE_W = 16;
  localparam int VOL_W    = 8;
  localparam int ACC_W    = 32;
  localparam int PAIR_W   = 2 * ACC_W;
  localparam int OUT_W    = 16;
  localparam int GAIN_W   = 2 * VOL_W;

  // Configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_MASTER_VOLUME  = 2'd0;
  localparam logic [1:0] REG_OUTPUT_FORMAT  = 2'd1;
  localparam logic [1:0] REG_RING_SIZE_LOG2 = 2'd2;

  localparam logic [VOL_W-1:0] MASTER_VOLUME_RST  = 8'd255;
  localparam logic [1:0]       OUTPUT_FORMAT_RST  = 2'd0;
  localparam logic [4:0]       RING_SIZE_LOG2_RST = 5'd14;
  localparam logic [4:0]       RING_LOG2_MAX      = 5'd16;

  // Output format bits
  localparam int FMT_MONO  = 0;
  localparam int FMT_EIGHT = 1;

  // Saturation and 8-bit conversion constants
  localparam logic [OUT_W-1:0] SAT_MAX  = 16'h7fff;
  localparam logic [OUT_W-1:0] SAT_MIN  = 16'h8000;
  localparam logic [7:0]       U8_BIAS  = 8'd128;
  localparam logic [7:0]       U8_FULL  = 8'd255;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_ACCUM = 2'd2,
    OP_DRAIN = 2'd3
  } op_t;

endpackage

>>> rtl/ssma_chan_if.sv
// Valid/ready channel interfaces for mix items and drained samples.
interface ssma_in_if import ssma_pkg::*; ();
  logic                        valid;
  logic                        ready;
  op_t                         operation;
  logic [POS_W-1:0]            buffer_position;
  logic signed [SAMPLE_W-1:0]  sample_value;
  logic [VOL_W-1:0]            left_volume;
  logic [VOL_W-1:0]            right_volume;
  logic signed [ACC_W-1:0]     raw_left;
  logic signed [ACC_W-1:0]     raw_right;

  modport source (output valid, operation, buffer_position, sample_value, left_volume,
                  right_volume, raw_left, raw_right, input ready);
  modport sink (input valid, operation, buffer_position, sample_value, left_volume,
                right_volume, raw_left, raw_right, output ready);
endinterface

interface ssma_out_if import ssma_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  left_out;
  logic signed [OUT_W-1:0]  right_out;
  logic [OUT_W-1:0]         ring_index;

  modport source (output valid, left_out, right_out, ring_index, input ready);
  modport sink (input valid, left_out, right_out, ring_index, output ready);
endinterface

>>> rtl/ssma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module ssma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/saturating_stereo_mix_accumulator.sv
// Stereo mix accumulator: item sequencer, mix store, drain conversion and APB registers.
//
// Usage:
//   in_ch  - valid/ready channel of mix items (clear, load, accumulate, drain)
//            addressed to one left/right accumulator pair of the mix store.
//   out_ch - valid/ready channel of drained samples with their ring index;
//            only a drain item produces a transfer here.
//   APB    - master_volume, output_format and ring_size_log2 at byte
//            addresses 0, 4 and 8; pready is tied high, reads return values.
// Timing: an item is worked on in order: accept plus gain multiply, read data plus
//   sample multiply, add and write-back. The store read and the product are
//   registered ahead of the add; in_ch.ready is high again in the cycle after
//   write-back. A drain result passes the store read, the write-back state and
//   the output register before it appears on out_ch.
// Reset: clears the sequencer, output valid, frame counter and registers
//   (master 255, format 0, ring log2 14). The mix store is not cleared:
//   each pair must be cleared or loaded before it is accumulated or drained.
// Stall: the output register holds a drained sample until taken; a further
//   drain waits in its write-back cycle while that sample is still pending.
module saturating_stereo_mix_accumulator import ssma_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  ssma_in_if.sink            in_ch,
  ssma_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_t;

  state_t state;

  // Configuration registers
  logic [VOL_W-1:0] master_volume;
  logic [1:0]       output_format;
  logic [4:0]       ring_size_log2;

  // Item held while it is worked on
  op_t                       item_op;
  logic [MIX_AW-1:0]         item_addr;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [ACC_W-1:0]          raw_l;
  logic [ACC_W-1:0]          raw_r;
  logic [GAIN_W-1:0]         gain_l;
  logic [GAIN_W-1:0]         gain_r;
  logic [ACC_W-1:0]          prod_l;
  logic [ACC_W-1:0]          prod_r;
  logic [ACC_W-1:0]          acc_l;
  logic [ACC_W-1:0]          acc_r;

  logic [ACC_W-1:0]          frame_counter;
  logic                      out_valid;
  logic [OUT_W-1:0]          left_r;
  logic [OUT_W-1:0]          right_r;
  logic [OUT_W-1:0]          ring_r;

  // Mix store port signals
  logic                      ram_we;
  logic [MIX_AW-1:0]         ram_raddr;
  logic [PAIR_W-1:0]         ram_wdata;
  logic [PAIR_W-1:0]         ram_rdata;

  logic                      in_xfer;
  logic                      out_load;
  logic                      cfg_write;
  logic [MIX_AW+POS_W-1:0]   pos_ext;
  logic signed [32:0]        prod_full_l;
  logic signed [32:0]        prod_full_r;
  logic [ACC_W-1:0]          sum_l;
  logic [ACC_W-1:0]          sum_r;
  logic [4:0]                ring_lg;
  logic [OUT_W-1:0]          ring_mask;
  logic [OUT_W-1:0]          ring_base;

  // Shift right by 8, saturate to 16 bits, optionally map to unsigned 8-bit.
  function automatic logic [OUT_W-1:0] conv_side(input logic [ACC_W-1:0] acc,
                                                 input logic eight);
    logic [ACC_W-9:0] v;
    logic [OUT_W-1:0] s;
    v = acc[ACC_W-1:8];
    if (!v[ACC_W-9] && (v[ACC_W-10:15] != '0)) begin
      s = SAT_MAX;
    end else if (v[ACC_W-9] && (v[ACC_W-10:15] != U8_FULL)) begin
      s = SAT_MIN;
    end else begin
      s = v[OUT_W-1:0];
    end
    if (eight) begin
      s = {8'h00, s[15:8] + U8_BIAS};
    end
    return s;
  endfunction

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  // Position wraps at the store depth
  assign pos_ext   = {{MIX_AW{1'b0}}, in_ch.buffer_position};
  assign ram_raddr = pos_ext[MIX_AW-1:0];

  // Gain is registered before the sample multiply; product before the add
  assign prod_full_l = 33'(sample_r) * 33'($signed({1'b0, gain_l}));
  assign prod_full_r = 33'(sample_r) * 33'($signed({1'b0, gain_r}));
  assign sum_l = acc_l + {{8{prod_l[ACC_W-1]}}, prod_l[ACC_W-1:8]};
  assign sum_r = acc_r + {{8{prod_r[ACC_W-1]}}, prod_r[ACC_W-1:8]};

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    if (state == S_EXEC) begin
      case (item_op)
        OP_CLEAR: begin
          ram_we    = 1'b1;
          ram_wdata = '0;
        end
        OP_LOAD: begin
          ram_we    = 1'b1;
          ram_wdata = {raw_r, raw_l};
        end
        OP_ACCUM: begin
          ram_we    = 1'b1;
          ram_wdata = {sum_r, sum_l};
        end
        default: begin
          ram_we    = 1'b0;
          ram_wdata = '0;
        end
      endcase
    end
  end

  // Drain output is loaded once the output register is free
  assign out_load = (state == S_EXEC) && (item_op == OP_DRAIN) &&
                    (!out_valid || out_ch.ready);

  // Ring index: frame * channels, masked by the ring size
  assign ring_lg   = (ring_size_log2 > RING_LOG2_MAX) ? RING_LOG2_MAX : ring_size_log2;
  assign ring_mask = (ring_lg >= RING_LOG2_MAX) ? '1 : ((OUT_W'(1) << ring_lg) - OUT_W'(1));
  assign ring_base = output_format[FMT_MONO] ? frame_counter[OUT_W-1:0]
                                             : {frame_counter[OUT_W-2:0], 1'b0};

  ssma_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (MIX_DEPTH)
  ) u_mix_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item_addr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Payload registers: latch the item, gains, store read data and products
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_op   <= in_ch.operation;
      item_addr <= ram_raddr;
      sample_r  <= in_ch.sample_value;
      raw_l     <= in_ch.raw_left;
      raw_r     <= in_ch.raw_right;
      gain_l    <= GAIN_W'(in_ch.left_volume) * GAIN_W'(master_volume);
      gain_r    <= GAIN_W'(in_ch.right_volume) * GAIN_W'(master_volume);
    end
    if (state == S_READ) begin
      acc_l  <= ram_rdata[ACC_W-1:0];
      acc_r  <= ram_rdata[PAIR_W-1:ACC_W];
      prod_l <= prod_full_l[ACC_W-1:0];
      prod_r <= prod_full_r[ACC_W-1:0];
    end
  end

  // Sequencer, output register and frame counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      frame_counter <= '0;
    end else begin
      // Drop valid once taken, unless a new drain refills the register
      if (out_valid && out_ch.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (item_op != OP_DRAIN) begin
            state <= S_IDLE;
          end else if (out_load) begin
            out_valid     <= 1'b1;
            left_r        <= conv_side(acc_l, output_format[FMT_EIGHT]);
            right_r       <= output_format[FMT_MONO] ? '0
                             : conv_side(acc_r, output_format[FMT_EIGHT]);
            ring_r        <= ring_base & ring_mask;
            frame_counter <= frame_counter + ACC_W'(1);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.left_out   = left_r;
  assign out_ch.right_out  = right_r;
  assign out_ch.ring_index = ring_r;

  // APB register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_volume  <= MASTER_VOLUME_RST;
      output_format  <= OUTPUT_FORMAT_RST;
      ring_size_log2 <= RING_SIZE_LOG2_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_MASTER_VOLUME:  master_volume  <= pwdata[VOL_W-1:0];
        REG_OUTPUT_FORMAT:  output_format  <= pwdata[1:0];
        REG_RING_SIZE_LOG2: ring_size_log2 <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MASTER_VOLUME:  prdata = CFG_DW'(master_volume);
      REG_OUTPUT_FORMAT:  prdata = CFG_DW'(output_format);
      REG_RING_SIZE_LOG2: prdata = CFG_DW'(ring_size_log2);
      default:            prdata = '0;
    endcase
  end

`ifndef SYNTH
  // An accepted item always goes on to the store read
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == S_READ))
    else $error("accepted item did not enter store read");

  // Write-back happens only in the modify cycle
  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_EXEC))
    else $error("mix store written outside write-back cycle");

  // Drain never modifies the store
  a_drain_no_write: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EXEC) && (item_op == OP_DRAIN)) |-> !ram_we)
    else $error("drain wrote the mix store");

  // Frame counter advances exactly with each drained sample
  a_frame_advance: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (frame_counter == $past(frame_counter) + ACC_W'(1)))
    else $error("frame counter did not advance on drain");

  a_frame_hold: assert property (@(posedge clk) disable iff (rst)
    !out_load |=> $stable(frame_counter))
    else $error("frame counter moved without a drain");
`endif

endmodule

>>> verif/tb_saturating_stereo_mix_accumulator.sv
`timescale 1ns / 100ps
// Self-checking testbench for the stereo mix accumulator: directed table, random mix, APB config.
module tb_saturating_stereo_mix_accumulator;
  import ssma_pkg::*;

  // One mix item as it crosses the input channel
  typedef struct packed {
    op_t                        op;
    logic [POS_W-1:0]           pos;
    logic signed [SAMPLE_W-1:0] sample;
    logic [VOL_W-1:0]           lvol;
    logic [VOL_W-1:0]           rvol;
    logic signed [ACC_W-1:0]    raw_l;
    logic signed [ACC_W-1:0]    raw_r;
  } mix_item_t;

  // One drained output sample pair with its ring position
  typedef struct packed {
    logic [OUT_W-1:0] left;
    logic [OUT_W-1:0] right;
    logic [OUT_W-1:0] ring;
  } drained_t;

  // Directed table row; typed rows carry a hand-written expectation
  typedef struct {
    mix_item_t item;
    bit        typed;
    drained_t  want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  ssma_in_if  mix_if ();
  ssma_out_if smp_if ();

  saturating_stereo_mix_accumulator DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (mix_if),
    .out_ch  (smp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Shadow of the block: mix store, frame counter and the three registers
  logic [PAIR_W-1:0] mix_pairs [MIX_DEPTH];
  logic [31:0]       frame_count;
  logic [VOL_W-1:0]  master_gain;
  logic [1:0]        out_format;
  logic [4:0]        ring_log2;

  // Pairs touched by a clear or load; only these may be accumulated or drained
  bit                pair_written [MIX_DEPTH];
  logic [POS_W-1:0]  written_list [$];

  drained_t pending_samples [$];
  int       mismatches = 0;
  int       burst_left = 0;
  int       items_sent = 0;

  // Add (sample * vol * master) >> 8 into one 32-bit accumulator side, with wrap
  function automatic logic [ACC_W-1:0] scale_into(input logic [ACC_W-1:0] acc,
                                                  input logic signed [SAMPLE_W-1:0] sample,
                                                  input logic [VOL_W-1:0] vol);
    logic [GAIN_W-1:0] gain;
    longint            prod;
    logic [31:0]       low;
    gain = vol * master_gain;
    prod = longint'(sample) * longint'(gain);
    low  = prod[31:0];
    return acc + 32'($signed(low) >>> 8);
  endfunction

  // Drop the 8 fraction bits, clamp to 16 bits, optionally rebias to unsigned 8-bit
  function automatic logic [OUT_W-1:0] saturate_side(input logic [ACC_W-1:0] acc,
                                                     input bit eight);
    int v;
    v = $signed(acc) >>> 8;
    if (v > 32767)
      v = 32767;
    else if (v < -32768)
      v = -32768;
    if (eight)
      v = (v + 32768) >>> 8;
    return v[OUT_W-1:0];
  endfunction

  // Apply one accepted item to the shadow state; returns 1 when it drains a sample
  function automatic bit apply_mix_item(input mix_item_t it, output drained_t res);
    logic [ACC_W-1:0] l_acc;
    logic [ACC_W-1:0] r_acc;
    logic [31:0]      lanes;
    logic [31:0]      mask;
    logic [31:0]      slot;
    int               lg;
    bit               mono;
    bit               eight;
    l_acc = mix_pairs[it.pos][ACC_W-1:0];
    r_acc = mix_pairs[it.pos][PAIR_W-1:ACC_W];
    res   = '0;
    case (it.op)
      OP_CLEAR: begin
        mix_pairs[it.pos] = '0;
      end
      OP_LOAD: begin
        mix_pairs[it.pos] = {it.raw_r, it.raw_l};
      end
      OP_ACCUM: begin
        mix_pairs[it.pos] = {scale_into(r_acc, it.sample, it.rvol),
                             scale_into(l_acc, it.sample, it.lvol)};
      end
      default: begin
        mono  = out_format[FMT_MONO];
        eight = out_format[FMT_EIGHT];
        lg    = (ring_log2 > 16) ? 16 : int'(ring_log2);
        mask  = (32'd1 << lg) - 32'd1;
        lanes = mono ? 32'd1 : 32'd2;
        slot  = (frame_count * lanes) & mask;
        res.left  = saturate_side(l_acc, eight);
        res.right = mono ? '0 : saturate_side(r_acc, eight);
        res.ring  = slot[OUT_W-1:0];
        frame_count = frame_count + 32'd1;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic mix_item_t mk_item(input op_t op, input logic [POS_W-1:0] pos,
                                        input logic [SAMPLE_W-1:0] sample,
                                        input logic [VOL_W-1:0] lvol,
                                        input logic [VOL_W-1:0] rvol,
                                        input logic [ACC_W-1:0] raw_l,
                                        input logic [ACC_W-1:0] raw_r);
    mix_item_t it;
    it.op     = op;
    it.pos    = pos;
    it.sample = sample;
    it.lvol   = lvol;
    it.rvol   = rvol;
    it.raw_l  = raw_l;
    it.raw_r  = raw_r;
    return it;
  endfunction

  // Random item with every field filled; extremes and mid-range values mixed in
  function automatic mix_item_t rand_item(input op_t op, input logic [POS_W-1:0] pos);
    mix_item_t it;
    it.op  = op;
    it.pos = pos;
    case ($urandom_range(0, 7))
      0:       it.sample = 16'h8000;
      1:       it.sample = 16'h7fff;
      2:       it.sample = $signed(16'($urandom)) >>> $urandom_range(4, 12);
      default: it.sample = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       it.lvol = '0;
      1:       it.lvol = '1;
      default: it.lvol = 8'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       it.rvol = '0;
      1:       it.rvol = '1;
      default: it.rvol = 8'($urandom);
    endcase
    // Keep many loads inside the 16-bit window so conversions are not all clamped
    case ($urandom_range(0, 5))
      0: begin
        it.raw_l = 32'h7fffffff;
        it.raw_r = 32'h80000000;
      end
      1, 2: begin
        it.raw_l = $urandom;
        it.raw_r = $urandom;
      end
      default: begin
        it.raw_l = $signed(32'($urandom)) >>> $urandom_range(6, 12);
        it.raw_r = $signed(32'($urandom)) >>> $urandom_range(6, 12);
      end
    endcase
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    $display("%0t ns: mismatch on %s, got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Present one item, hold it until the transfer, then update the shadow state.
  // The sender runs in bursts; a burst ending inserts an idle gap on valid.
  task automatic send_item(input mix_item_t it, input bit typed, input drained_t want);
    drained_t model_res;
    bit       drains;
    if (burst_left == 0) begin
      mix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 12);
    end
    mix_if.valid           <= 1'b1;
    mix_if.operation       <= it.op;
    mix_if.buffer_position <= it.pos;
    mix_if.sample_value    <= it.sample;
    mix_if.left_volume     <= it.lvol;
    mix_if.right_volume    <= it.rvol;
    mix_if.raw_left        <= it.raw_l;
    mix_if.raw_right       <= it.raw_r;
    do @(posedge clk); while (!mix_if.ready);
    burst_left--;
    items_sent++;
    if ((it.op == OP_CLEAR || it.op == OP_LOAD) && !pair_written[it.pos]) begin
      pair_written[it.pos] = 1'b1;
      written_list.push_back(it.pos);
    end
    drains = apply_mix_item(it, model_res);
    if (drains)
      pending_samples.push_back(typed ? want : model_res);
  endtask

  // Drop valid, wait for every drained sample, then let the pipeline empty
  task automatic settle();
    mix_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Two-phase APB write; the register takes the value at the access edge with pready
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MASTER_VOLUME:  master_gain = val[VOL_W-1:0];
      REG_OUTPUT_FORMAT:  out_format  = val[1:0];
      REG_RING_SIZE_LOG2: ring_log2   = val[4:0];
      default: ;
    endcase
  endtask

  // Random mix: mostly well-formed clear/load, accumulate, drain runs on one pair,
  // the rest single items of any operation on any legal pair
  task automatic run_mix_phase(input int count);
    int               target;
    logic [POS_W-1:0] pos;
    op_t              op;
    drained_t         none;
    none   = '0;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 75) begin
        pos = POS_W'($urandom);
        op  = $urandom_range(0, 1) ? OP_LOAD : OP_CLEAR;
        send_item(rand_item(op, pos), 1'b0, none);
        repeat ($urandom_range(0, 5)) send_item(rand_item(OP_ACCUM, pos), 1'b0, none);
        repeat ($urandom_range(1, 2)) send_item(rand_item(OP_DRAIN, pos), 1'b0, none);
      end else begin
        op  = op_t'($urandom_range(0, 3));
        pos = POS_W'($urandom);
        // Never read a pair the block has not written; pick a known one instead
        if ((op == OP_ACCUM || op == OP_DRAIN) && !pair_written[pos])
          pos = written_list[$urandom_range(0, written_list.size() - 1)];
        send_item(rand_item(op, pos), 1'b0, none);
      end
    end
  endtask

  // Receiver: take drained samples under a changing stall pattern and check them
  initial begin
    int       ready_pct;
    int       pattern_left;
    drained_t want;
    ready_pct    = 100;
    pattern_left = 0;
    smp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (smp_if.valid && smp_if.ready) begin
        if (pending_samples.size() == 0) begin
          report_mismatch("unexpected drained sample", smp_if.left_out, '0);
        end else begin
          want = pending_samples.pop_front();
          if (smp_if.left_out !== want.left)
            report_mismatch("left_out", smp_if.left_out, want.left);
          if (smp_if.right_out !== want.right)
            report_mismatch("right_out", smp_if.right_out, want.right);
          if (smp_if.ring_index !== want.ring)
            report_mismatch("ring_index", smp_if.ring_index, want.ring);
        end
      end
      // Switch between free-flowing, light, heavy and near-blocked stretches
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pct = 100;
          1:       ready_pct = 70;
          2:       ready_pct = 25;
          default: ready_pct = 4;
        endcase
        pattern_left = $urandom_range(20, 200);
      end
      pattern_left--;
      smp_if.ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #800000;
    $display("saturating_stereo_mix_accumulator test failed");
    $finish;
  end

  // Main sequence: reset, directed table at reset settings, then random phases
  initial begin
    table_row_t rows [$];
    drained_t   none;
    logic [7:0] m;
    logic [1:0] f;
    logic [4:0] g;
    none = '0;

    // Drive every input to a known value before the first edge
    rst                    <= 1'b1;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    mix_if.valid           <= 1'b0;
    mix_if.operation       <= OP_CLEAR;
    mix_if.buffer_position <= '0;
    mix_if.sample_value    <= '0;
    mix_if.left_volume     <= '0;
    mix_if.right_volume    <= '0;
    mix_if.raw_left        <= '0;
    mix_if.raw_right       <= '0;

    // Shadow registers start at their reset values
    frame_count = '0;
    master_gain = MASTER_VOLUME_RST;
    out_format  = OUTPUT_FORMAT_RST;
    ring_log2   = RING_SIZE_LOG2_RST;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at reset settings: stereo, 16-bit, ring of 2^14.
    // Full-scale loads saturate both ways; a cleared pair drains to zero.
    rows.push_back('{mk_item(OP_LOAD, 12'h000, 16'h0000, 8'h00, 8'h00,
                             32'h7fffffff, 32'h80000000), 1'b0, none});
    rows.push_back('{mk_item(OP_DRAIN, 12'h000, 16'hffff, 8'hff, 8'hff, '1, '1),
                     1'b1, '{16'h7fff, 16'h8000, 16'd0}});
    rows.push_back('{mk_item(OP_CLEAR, 12'hfff, 16'hffff, 8'hff, 8'hff, '1, '1), 1'b0, none});
    rows.push_back('{mk_item(OP_DRAIN, 12'hfff, 16'h0000, 8'h00, 8'h00, '0, '0),
                     1'b1, '{16'h0000, 16'h0000, 16'd2}});
    // Small values pass unclamped; -256 drains to -1
    rows.push_back('{mk_item(OP_LOAD, 12'h800, 16'h0000, 8'h00, 8'h00,
                             32'h00012300, 32'hffffff00), 1'b0, none});
    rows.push_back('{mk_item(OP_DRAIN, 12'h800, 16'h0000, 8'h00, 8'h00, '0, '0),
                     1'b1, '{16'h0123, 16'hffff, 16'd4}});
    // Exactly at the 16-bit limits
    rows.push_back('{mk_item(OP_LOAD, 12'h7ff, 16'h0000, 8'h00, 8'h00,
                             32'h007fff00, 32'hff800000), 1'b0, none});
    rows.push_back('{mk_item(OP_DRAIN, 12'h7ff, 16'h0000, 8'h00, 8'h00, '0, '0),
                     1'b1, '{16'h7fff, 16'h8000, 16'd6}});
    // One step beyond the limits clamps
    rows.push_back('{mk_item(OP_LOAD, 12'h001, 16'h0000, 8'h00, 8'h00,
                             32'h00800000, 32'hff7fffff), 1'b0, none});
    rows.push_back('{mk_item(OP_DRAIN, 12'h001, 16'h0000, 8'h00, 8'h00, '0, '0),
                     1'b1, '{16'h7fff, 16'h8000, 16'd8}});
    // Accumulate extremes of sample and gain, then drain twice: the pair stays
    rows.push_back('{mk_item(OP_ACCUM, 12'hfff, 16'h7fff, 8'hff, 8'h00, '0, '0), 1'b0, none});
    rows.push_back('{mk_item(OP_ACCUM, 12'hfff, 16'h8000, 8'hff, 8'hff, '0, '0), 1'b0, none});
    rows.push_back('{mk_item(OP_ACCUM, 12'hfff, 16'hffff, 8'h01, 8'h80, '0, '0), 1'b0, none});
    rows.push_back('{mk_item(OP_DRAIN, 12'hfff, 16'h0000, 8'h00, 8'h00, '0, '0), 1'b0, none});
    rows.push_back('{mk_item(OP_DRAIN, 12'hfff, 16'h0000, 8'h00, 8'h00, '0, '0), 1'b0, none});
    // Alternating bit patterns on every field
    rows.push_back('{mk_item(OP_LOAD, 12'h555, 16'h5555, 8'h55, 8'haa,
                             32'h55555555, 32'haaaaaaaa), 1'b0, none});
    rows.push_back('{mk_item(OP_ACCUM, 12'h555, 16'h5555, 8'haa, 8'h55, '0, '0), 1'b0, none});
    rows.push_back('{mk_item(OP_DRAIN, 12'h555, 16'h0000, 8'h00, 8'h00, '0, '0), 1'b0, none});
    rows.push_back('{mk_item(OP_LOAD, 12'haaa, 16'haaaa, 8'haa, 8'h55,
                             32'haaaaaaaa, 32'h55555555), 1'b0, none});
    rows.push_back('{mk_item(OP_ACCUM, 12'haaa, 16'haaaa, 8'h55, 8'haa, '0, '0), 1'b0, none});
    rows.push_back('{mk_item(OP_DRAIN, 12'haaa, 16'h0000, 8'h00, 8'h00, '0, '0), 1'b0, none});
    // Accumulator wrap past the positive end on the left side
    rows.push_back('{mk_item(OP_LOAD, 12'h123, 16'h0000, 8'h00, 8'h00,
                             32'h7fffff00, 32'h80000000), 1'b0, none});
    rows.push_back('{mk_item(OP_ACCUM, 12'h123, 16'h7fff, 8'hff, 8'hff, '0, '0), 1'b0, none});
    rows.push_back('{mk_item(OP_DRAIN, 12'h123, 16'h0000, 8'h00, 8'h00, '0, '0), 1'b0, none});

    foreach (rows[i])
      send_item(rows[i].item, rows[i].typed, rows[i].want);
    settle();

    // Random phases; the first four pin the register extremes:
    // mono with ring of 2, 8-bit with full ring, both with zero log2, log2 above 16
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          m = 8'd0;   f = 2'd1; g = 5'd1;
        end
        1: begin
          m = 8'd255; f = 2'd2; g = RING_LOG2_MAX;
        end
        2: begin
          m = 8'd1;   f = 2'd3; g = 5'd0;
        end
        3: begin
          m = 8'd128; f = 2'd0; g = 5'd31;
        end
        default: begin
          m = 8'($urandom);
          f = 2'($urandom);
          g = 5'($urandom);
        end
      endcase
      write_reg(REG_MASTER_VOLUME, {24'd0, m});
      write_reg(REG_OUTPUT_FORMAT, {30'd0, f});
      write_reg(REG_RING_SIZE_LOG2, {27'd0, g});
      run_mix_phase(262);
      settle();
    end

    // Any late result after the settle would have been flagged by the receiver
    repeat (12) @(posedge clk);
    if (mismatches == 0 && pending_samples.size() == 0)
      $display("saturating_stereo_mix_accumulator test passed");
    else
      $display("saturating_stereo_mix_accumulator test failed");
    $finish;
  end

endmodule
